// ----- rtl/hpcl_pkg.sv -----
// ----------------------------------------------------------------------------
// hpcl_pkg
// Shared constants, command codes, control structs and hash helpers for the
// hashed palette code lookup unit.
// ----------------------------------------------------------------------------
package hpcl_pkg;

  localparam int HASH_BITS    = 8;
  localparam int BUCKET_DEPTH = 16;
  localparam int MAX_CHARS    = 4;

  localparam int NUM_BUCKETS = 1 << HASH_BITS;
  localparam int FILL_W      = $clog2(BUCKET_DEPTH + 1);
  localparam int IDX_W       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int SLOT_W      = HASH_BITS + IDX_W;
  localparam int NUM_SLOTS   = 1 << SLOT_W;
  localparam int CHAR_LIM    = (MAX_CHARS < 4) ? MAX_CHARS : 4;

  localparam int OP_W    = 2;
  localparam int CPP_W   = 3;
  localparam int KEY_W   = 32;
  localparam int COLOR_W = 32;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [CPP_W-1:0] CPP_RESET = 3'd1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the accepted item, clear staged result
    logic wr_load;   // append entry to bucket
    logic set_ovf;   // load dropped, bucket full
    logic clr_all;   // empty every bucket
    logic scan_en;   // bucket scan in progress
    logic set_hit;   // stage matched color
    logic out_load;  // move staged result to output register
  } hpcl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            hit;
    logic            miss;
  } hpcl_sts_t;

  // effective character count, clamped to 1..CHAR_LIM
  function automatic logic [CPP_W-1:0] char_count(input logic [CPP_W-1:0] cpp);
    logic [CPP_W-1:0] n;
    if (cpp == '0) begin
      n = CPP_W'(1);
    end else if (int'(cpp) > CHAR_LIM) begin
      n = CPP_W'(CHAR_LIM);
    end else begin
      n = cpp;
    end
    return n;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(input logic [CPP_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(n)) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // shift-and-add over the first n bytes
  function automatic logic [HASH_BITS-1:0] hash_key(input logic [KEY_W-1:0] key,
                                                    input logic [CPP_W-1:0] n);
    logic [31:0] h;
    h = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < int'(n)) h = h + (32'(key[8*i +: 8]) << i);
    end
    return h[HASH_BITS-1:0];
  endfunction

endpackage

// ----- rtl/hpcl_dp.sv -----
// ----------------------------------------------------------------------------
// hpcl_dp
// Datapath: config register, item registers, bucket fill memory with
// per-bucket valid bits, entry key/value memories, scan compare, result regs.
// ----------------------------------------------------------------------------
module hpcl_dp
  import hpcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpcl_cmd_t          cmd_i,
  output hpcl_sts_t          sts_o,
  input  logic               cfg_we_i,
  input  logic [CPP_W-1:0]   cfg_wdata_i,
  input  logic [OP_W-1:0]    command_i,
  input  logic [KEY_W-1:0]   key_code_i,
  input  logic [COLOR_W-1:0] entry_color_i,
  output logic [COLOR_W-1:0] color_o,
  output logic               found_o,
  output logic               overflow_o
);

  logic [CPP_W-1:0]     cpp_q;
  logic [OP_W-1:0]      op_q;
  logic [KEY_W-1:0]     key_q;
  logic [COLOR_W-1:0]   col_q;

  logic [CPP_W-1:0]     n_cnt;
  logic [KEY_W-1:0]     mask;
  logic [HASH_BITS-1:0] hash;

  logic [FILL_W-1:0]    fill_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] bkt_vld_q;
  logic [FILL_W-1:0]    fill_rd_q;
  logic                 fill_vld_q;
  logic [FILL_W-1:0]    fill_eff;

  logic [KEY_W-1:0]     key_mem [NUM_SLOTS];
  logic [COLOR_W-1:0]   val_mem [NUM_SLOTS];
  logic [KEY_W-1:0]     key_rd_q;
  logic [COLOR_W-1:0]   val_rd_q;
  logic [SLOT_W-1:0]    wr_addr;
  logic [SLOT_W-1:0]    rd_addr;

  logic [FILL_W-1:0]    idx_q;
  logic                 pend_q;
  logic                 more;
  logic                 hit;
  logic                 issue;

  logic [COLOR_W-1:0]   res_color_q;
  logic                 res_found_q;
  logic                 res_ovf_q;
  logic [COLOR_W-1:0]   color_q;
  logic                 found_q;
  logic                 ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpp_q <= CPP_RESET;
    end else if (cfg_we_i) begin
      cpp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= command_i;
      key_q <= key_code_i;
      col_q <= entry_color_i;
    end
  end

  assign n_cnt = char_count(cpp_q);
  assign mask  = key_mask(n_cnt);
  assign hash  = hash_key(key_q, n_cnt);

  // bucket fill counts; an invalid bucket reads as empty
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load) fill_mem[hash] <= fill_eff + FILL_W'(1);
    fill_rd_q <= fill_mem[hash];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bkt_vld_q  <= '0;
      fill_vld_q <= 1'b0;
    end else begin
      fill_vld_q <= bkt_vld_q[hash];
      if (cmd_i.clr_all) begin
        bkt_vld_q <= '0;
      end else if (cmd_i.wr_load) begin
        bkt_vld_q[hash] <= 1'b1;
      end
    end
  end

  assign fill_eff = fill_vld_q ? fill_rd_q : '0;

  // entry storage
  assign wr_addr = {hash, fill_eff[IDX_W-1:0]};
  assign rd_addr = {hash, idx_q[IDX_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_load) begin
      key_mem[wr_addr] <= key_q;
      val_mem[wr_addr] <= col_q;
    end
    key_rd_q <= key_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // scan: read slot idx while comparing the slot read last cycle
  assign hit   = pend_q && (((key_rd_q ^ key_q) & mask) == '0);
  assign more  = (idx_q < fill_eff);
  assign issue = cmd_i.scan_en && !hit && more;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= issue;
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (issue) begin
        idx_q <= idx_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_color_q <= '0;
      res_found_q <= 1'b0;
      res_ovf_q   <= 1'b0;
    end else begin
      if (cmd_i.set_ovf) res_ovf_q <= 1'b1;
      if (cmd_i.set_hit) begin
        res_color_q <= val_rd_q;
        res_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      color_q <= res_color_q;
      found_q <= res_found_q;
      ovf_q   <= res_ovf_q;
    end
  end

  assign color_o    = color_q;
  assign found_o    = found_q;
  assign overflow_o = ovf_q;

  assign sts_o.op   = op_q;
  assign sts_o.full = (fill_eff >= FILL_W'(BUCKET_DEPTH));
  assign sts_o.hit  = hit;
  assign sts_o.miss = !pend_q && !more;

  a_load_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_load |-> (fill_eff < FILL_W'(BUCKET_DEPTH)))
    else $error("entry written into a full bucket");

  a_pend_from_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(cmd_i.scan_en))
    else $error("slot read pending outside a scan");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> cmd_i.scan_en)
    else $error("slot compare after the scan ended");

endmodule

// ----- rtl/hpcl_ctrl.sv -----
// ----------------------------------------------------------------------------
// hpcl_ctrl
// Controller: sequences fill fetch, load/clear, bucket scan and result
// handoff; owns the input ready and output valid.
// ----------------------------------------------------------------------------
module hpcl_ctrl
  import hpcl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hpcl_cmd_t cmd_o,
  input  hpcl_sts_t sts_i
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_FETCH  = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_RESULT = 5'b10000
  } state_e;

  state_e st_q, st_d;
  logic   out_vld_q;
  logic   accept;

  assign accept = in_valid_i && (st_q == ST_IDLE);

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          st_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        st_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        st_d = ST_RESULT;
        case (sts_i.op)
          OP_LOAD: begin
            if (sts_i.full) cmd_o.set_ovf = 1'b1;
            else            cmd_o.wr_load = 1'b1;
          end
          OP_LOOKUP: st_d = ST_SCAN;
          OP_CLEAR:  cmd_o.clr_all = 1'b1;
          default: ;
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.hit) begin
          cmd_o.set_hit = 1'b1;
          st_d = ST_RESULT;
        end else if (sts_i.miss) begin
          st_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cmd_o.out_load)   out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_vld_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready still high after an item was taken");

  a_scan_is_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> (sts_i.op == OP_LOOKUP))
    else $error("bucket scan for a non-lookup item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result item dropped before it was taken");

endmodule

// ----- rtl/hashed_palette_code_lookup_unit.sv -----
// Sequencing: an item is taken in IDLE and passes FETCH and DECIDE; a lookup then scans its
//   bucket in SCAN; RESULT moves it to the output register once any earlier result is taken.
// Items: one item at a time; the next item is taken in IDLE, only after the result is
//   registered, and a lookup takes longer the more bucket slots its scan has to read.
// Reset: asynchronous, active low; empties every bucket and sets chars_per_pixel to 1.
// Entry memories are not cleared; only slots below a bucket's fill are ever read.
// ----------------------------------------------------------------------------
// hashed_palette_code_lookup_unit
// Palette lookup for character-coded pixels: load, lookup and clear items on
// a hashed table of fixed-depth buckets.
// ----------------------------------------------------------------------------
module hashed_palette_code_lookup_unit
  import hpcl_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CPP_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OP_W-1:0]    command_i,
  input  logic [KEY_W-1:0]   key_code_i,
  input  logic [COLOR_W-1:0] entry_color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COLOR_W-1:0] color_o,
  output logic               found_o,
  output logic               overflow_o
);

  hpcl_cmd_t cmd;
  hpcl_sts_t sts;

  hpcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  hpcl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .key_code_i    (key_code_i),
    .entry_color_i (entry_color_i),
    .color_o       (color_o),
    .found_o       (found_o),
    .overflow_o    (overflow_o)
  );

endmodule
